// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by baro_sensor_compensation_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`endif

// ===== hw/rtl/bsc_pkg.sv =====
// types, constants and opcodes for the barometric compensation block
// no dependencies
package bsc_pkg;

    typedef struct packed {
        logic [23:0] raw_press;
        logic [15:0] raw_temp;
    } t_in_beat;

    typedef struct packed {
        logic        press_changed;
        logic        temp_changed;
        logic [31:0] press_pa;
        logic [31:0] temp_tenths;
    } t_out_beat;

    localparam logic [2:0] REG_CAL_A = 3'd0;
    localparam logic [2:0] REG_CAL_B = 3'd1;
    localparam logic [2:0] REG_CAL_C = 3'd2;
    localparam logic [2:0] REG_OSS   = 3'd3;
    localparam logic [2:0] REG_TTHR  = 3'd4;
    localparam logic [2:0] REG_PTHR  = 3'd5;

    // micro-operations of the datapath
    typedef enum logic [4:0] {
        OP_LOAD   = 5'd0,
        OP_X1T    = 5'd1,
        OP_DIVT   = 5'd2,
        OP_B5     = 5'd3,
        OP_B6SQ   = 5'd4,
        OP_B2M    = 5'd5,
        OP_AC2M   = 5'd6,
        OP_B3     = 5'd7,
        OP_AC3M   = 5'd8,
        OP_B1M    = 5'd9,
        OP_X3     = 5'd10,
        OP_B4     = 5'd11,
        OP_B7     = 5'd12,
        OP_DIVP   = 5'd13,
        OP_PFIX   = 5'd14,
        OP_PSQ    = 5'd15,
        OP_P3038  = 5'd16,
        OP_P7357  = 5'd17,
        OP_PEND   = 5'd18,
        OP_FLAGS  = 5'd19,
        OP_NONE   = 5'd20
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

endpackage

// ===== hw/rtl/baro_sensor_compensation_core.sv =====
// Compensates one raw temperature/pressure pair per beat with the integer
// datasheet algorithm. An item passes through two divisions in a shared
// radix-2 divider and through the datapath ops around one 32x32 multiplier; the
// next item is taken in the cycle after the result beat has left, so the block
// takes no new item while one is in flight. Registers sit at byte address 8*i
// over the APB port. depends on bsc_pkg, bsc_ctrl, bsc_datapath, assert_macros.svh.
`include "assert_macros.svh"
module baro_sensor_compensation_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bsc_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bsc_pkg::t_out_beat o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import bsc_pkg::*;

    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;
    logic [9:0]  r_tthr;
    logic [15:0] r_pthr;
    logic [2:0]  reg_idx;
    t_cmd        cmd;
    t_sts        sts;

    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= 2'd1;
            r_tthr  <= 10'd5;
            r_pthr  <= 16'd100;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_CAL_A: r_cal_a <= pwdata;
                REG_CAL_B: r_cal_b <= pwdata;
                REG_CAL_C: r_cal_c <= pwdata[31:0];
                REG_OSS:   r_oss   <= pwdata[1:0];
                REG_TTHR:  r_tthr  <= pwdata[9:0];
                REG_PTHR:  r_pthr  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CAL_A: prdata = r_cal_a;
            REG_CAL_B: prdata = r_cal_b;
            REG_CAL_C: prdata = {32'd0, r_cal_c};
            REG_OSS:   prdata = {62'd0, r_oss};
            REG_TTHR:  prdata = {54'd0, r_tthr};
            REG_PTHR:  prdata = {48'd0, r_pthr};
            default:   prdata = '0;
        endcase
    end

    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bsc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in_data),
        .i_cal_a (r_cal_a),
        .i_cal_b (r_cal_b),
        .i_cal_c (r_cal_c),
        .i_oss   (r_oss),
        .i_tthr  (r_tthr),
        .i_pthr  (r_pthr),
        .o_res   (o_out_data)
    );

    `ASSERT_ALWAYS(a_ready_excl, i_clk, i_rst_n, !(o_in_ready && o_out_valid))
    `ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule

// ===== hw/rtl/bsc_div.sv =====
// radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle
// depends on bsc_pkg
module bsc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quo
);
    import bsc_pkg::*;

    logic [31:0] r_rem, r_quo, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    assign n_shift = {r_rem, r_quo[31]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (n_trial[32]) begin
                r_rem <= n_shift[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end else begin
                r_rem <= n_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // a zero divisor naturally yields all ones
    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// ===== hw/rtl/bsc_datapath.sv =====
// compensation datapath: one 32x32 multiplier, shared divider, flag logic
// depends on bsc_pkg and bsc_div
module bsc_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsc_pkg::t_cmd    i_cmd,
    output bsc_pkg::t_sts    o_sts,
    input  bsc_pkg::t_in_beat i_in,
    input  logic [63:0]      i_cal_a,
    input  logic [63:0]      i_cal_b,
    input  logic [31:0]      i_cal_c,
    input  logic [1:0]       i_oss,
    input  logic [9:0]       i_tthr,
    input  logic [15:0]      i_pthr,
    output bsc_pkg::t_out_beat o_res
);
    import bsc_pkg::*;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{i_cal_a[15]}}, i_cal_a[15:0]};
    assign ac2 = {{16{i_cal_a[31]}}, i_cal_a[31:16]};
    assign ac3 = {{16{i_cal_a[47]}}, i_cal_a[47:32]};
    assign ac4 = {16'd0, i_cal_a[63:48]};
    assign ac5 = {16'd0, i_cal_b[15:0]};
    assign ac6 = {16'd0, i_cal_b[31:16]};
    assign b1  = {{16{i_cal_b[47]}}, i_cal_b[47:32]};
    assign b2  = {{16{i_cal_b[63]}}, i_cal_b[63:48]};
    assign mc  = {{16{i_cal_c[15]}}, i_cal_c[15:0]};
    assign md  = {{16{i_cal_c[31]}}, i_cal_c[31:16]};

    logic [31:0] r_ut, r_up, r_x1, r_x2, r_b3, r_b4, r_b6, r_sq, r_b7, r_p, r_temp;
    logic [31:0] r_last_t, r_last_p;
    logic        r_neg, r_b7hi, r_tch, r_pch;

    logic        div_busy;
    logic [31:0] div_quo, n_num, n_den;
    logic [31:0] n_ma, n_mb, prod;

    // shared multiplier, operands chosen by the op
    always_comb begin
        n_ma = r_x1;
        n_mb = r_x1;
        case (i_cmd.op)
            OP_X1T:   begin n_ma = r_ut - ac6;         n_mb = ac5; end
            OP_B6SQ:  begin n_ma = r_b6;               n_mb = r_b6; end
            OP_B2M:   begin n_ma = b2;                 n_mb = r_sq; end
            OP_AC2M:  begin n_ma = ac2;                n_mb = r_b6; end
            OP_AC3M:  begin n_ma = ac3;                n_mb = r_b6; end
            OP_B1M:   begin n_ma = b1;                 n_mb = asr32(r_sq, 12); end
            OP_B4:    begin n_ma = ac4;                n_mb = r_x1 + 32'd32768; end
            OP_B7:    begin n_ma = r_up - r_b3;        n_mb = 32'd50000 >> i_oss; end
            OP_PSQ:   begin n_ma = asr32(r_p, 8);      n_mb = asr32(r_p, 8); end
            OP_P3038: begin n_ma = r_x1;               n_mb = 32'd3038; end
            OP_P7357: begin n_ma = 32'd0 - 32'd7357;   n_mb = r_p; end
            default:  begin n_ma = r_x1;               n_mb = r_x1; end
        endcase
    end
    assign prod = n_ma * n_mb;

    // divider operands
    logic [31:0] tnum, tden;
    assign tnum = mc << 11;
    assign tden = r_x1 + md;
    always_comb begin
        if (i_cmd.op == OP_DIVT) begin
            n_num = tnum[31] ? 32'd0 - tnum : tnum;
            n_den = tden[31] ? 32'd0 - tden : tden;
        end else begin
            n_num = r_b7hi ? r_b7 : {r_b7[30:0], 1'b0};
            n_den = r_b4;
        end
    end

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    logic [31:0] b3s, pnew;
    logic [33:0] tw, tl, pw, pl;
    assign b3s = (((ac1 << 2) + r_x1 + r_x2) << i_oss) + 32'd2;
    assign pnew = r_p + asr32(r_x1 + r_x2 + 32'd3791, 4);
    assign tw = {{2{r_temp[31]}}, r_temp};
    assign tl = {{2{r_last_t[31]}}, r_last_t};
    assign pw = {{2{r_p[31]}}, r_p};
    assign pl = {{2{r_last_p[31]}}, r_last_p};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_t <= '0;
            r_last_p <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_ut <= {16'd0, i_in.raw_temp};
                    r_up <= {8'd0, i_in.raw_press} >> (4'd8 - {2'd0, i_oss});
                end
                OP_X1T:  r_x1 <= asr32(prod, 15);
                OP_DIVT: r_neg <= (tnum[31] ^ tden[31]) && (tden != 32'd0);
                OP_B5: begin
                    r_x2   <= r_x1 + (r_neg ? 32'd0 - div_quo : div_quo);
                    r_temp <= asr32(r_x1 + (r_neg ? 32'd0 - div_quo : div_quo) + 32'd8, 4);
                    r_b6   <= r_x1 + (r_neg ? 32'd0 - div_quo : div_quo) - 32'd4000;
                end
                OP_B6SQ: r_sq <= prod;
                OP_B2M:  r_x1 <= asr32(asr32(prod, 12), 11);
                OP_AC2M: r_x2 <= asr32(prod, 11);
                OP_B3:   r_b3 <= asr32(b3s, 2);
                OP_AC3M: r_x1 <= asr32(prod, 13);
                OP_B1M:  r_x2 <= asr32(prod, 16);
                OP_X3:   r_x1 <= asr32(r_x1 + r_x2 + 32'd2, 2);
                OP_B4:   r_b4 <= prod >> 15;
                OP_B7: begin
                    r_b7   <= prod;
                    r_b7hi <= prod[31];
                end
                OP_PFIX: r_p <= r_b7hi ? {div_quo[30:0], 1'b0} : div_quo;
                OP_PSQ:  r_x1 <= prod;
                OP_P3038: r_x1 <= asr32(prod, 16);
                OP_P7357: r_x2 <= asr32(prod, 16);
                OP_PEND: r_p <= pnew;
                OP_FLAGS: begin
                    r_tch <= ($signed(tw) > $signed(tl + {24'd0, i_tthr}))
                          || ($signed(tw) < $signed(tl - {24'd0, i_tthr}));
                    r_pch <= ($signed(pw) > $signed(pl + {18'd0, i_pthr}))
                          || ($signed(pw) < $signed(pl - {18'd0, i_pthr}));
                    if (($signed(tw) > $signed(tl + {24'd0, i_tthr}))
                        || ($signed(tw) < $signed(tl - {24'd0, i_tthr}))) r_last_t <= r_temp;
                    if (($signed(pw) > $signed(pl + {18'd0, i_pthr}))
                        || ($signed(pw) < $signed(pl - {18'd0, i_pthr}))) r_last_p <= r_p;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.div_busy      = div_busy;
    assign o_res.temp_tenths   = r_temp;
    assign o_res.press_pa      = r_p;
    assign o_res.temp_changed  = r_tch;
    assign o_res.press_changed = r_pch;
endmodule

// ===== hw/rtl/bsc_ctrl.sv =====
// sequencer: steps the datapath through the compensation and handles the beats
// depends on bsc_pkg
module bsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bsc_pkg::t_cmd o_cmd,
    input  bsc_pkg::t_sts i_sts
);
    import bsc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_WAIT = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   n_start;

    function automatic t_op next_op(input t_op op);
        case (op)
            OP_LOAD:  next_op = OP_X1T;
            OP_X1T:   next_op = OP_DIVT;
            OP_DIVT:  next_op = OP_B5;
            OP_B5:    next_op = OP_B6SQ;
            OP_B6SQ:  next_op = OP_B2M;
            OP_B2M:   next_op = OP_AC2M;
            OP_AC2M:  next_op = OP_B3;
            OP_B3:    next_op = OP_AC3M;
            OP_AC3M:  next_op = OP_B1M;
            OP_B1M:   next_op = OP_X3;
            OP_X3:    next_op = OP_B4;
            OP_B4:    next_op = OP_B7;
            OP_B7:    next_op = OP_DIVP;
            OP_DIVP:  next_op = OP_PFIX;
            OP_PFIX:  next_op = OP_PSQ;
            OP_PSQ:   next_op = OP_P3038;
            OP_P3038: next_op = OP_P7357;
            OP_P7357: next_op = OP_PEND;
            OP_PEND:  next_op = OP_FLAGS;
            default:  next_op = OP_NONE;
        endcase
    endfunction

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_start = 1'b0;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_op = OP_X1T;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.op = r_op;
                if (r_op == OP_DIVT || r_op == OP_DIVP) begin
                    n_start = 1'b1;
                    n_state = S_WAIT;
                end else if (r_op == OP_FLAGS) begin
                    n_state = S_OUT;
                end
                n_op = next_op(r_op);
            end
            S_WAIT: begin
                if (!i_sts.div_busy) n_state = S_DONE;
            end
            S_DONE: n_state = S_RUN;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // divider starts with its op, so its busy is already high in S_WAIT
        o_cmd.div_start = n_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule

// ===== tb/sv/baro_sensor_compensation_core_tb.sv =====
// testbench for the barometric compensation core: directed and random beats
// checked against an in-bench integer compensation predictor
// depends on bsc_pkg and baro_sensor_compensation_core
`timescale 1ns / 1ps
module baro_sensor_compensation_core_tb;
    import bsc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_beat    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_beat   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    baro_sensor_compensation_core DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [63:0] cal_a, cal_b;
    logic [31:0] cal_c;
    logic [1:0]  oss_set;
    logic [9:0]  tthr;
    logic [15:0] pthr;
    logic [31:0] last_temp, last_press;
    t_out_beat   pending_results[$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;

    function automatic logic [31:0] sext16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] signed_quot(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] mn, md, q;
        if (d == 0) return '1;
        mn = n[31] ? -n : n;
        md = d[31] ? -d : d;
        q = mn / md;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] unsigned_quot(input logic [31:0] n, input logic [31:0] d);
        if (d == 0) return '1;
        return n / d;
    endfunction

    function automatic bit outside_band(input logic [31:0] v, input logic [31:0] last,
                                        input logic [31:0] thr);
        longint t, l;
        t = longint'($signed(v));
        l = longint'($signed(last));
        return (t > l + longint'(thr)) || (t < l - longint'(thr));
    endfunction

    function automatic t_out_beat compensate(input t_in_beat b);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, temp;
        t_out_beat r;
        ac1 = sext16(cal_a[15:0]);  ac2 = sext16(cal_a[31:16]);
        ac3 = sext16(cal_a[47:32]); ac4 = {16'd0, cal_a[63:48]};
        ac5 = {16'd0, cal_b[15:0]}; ac6 = {16'd0, cal_b[31:16]};
        b1 = sext16(cal_b[47:32]);  b2 = sext16(cal_b[63:48]);
        mc = sext16(cal_c[15:0]);   md = sext16(cal_c[31:16]);
        ut = {16'd0, b.raw_temp};
        up = {8'd0, b.raw_press} >> (8 - oss_set);
        x1 = sra((ut - ac6) * ac5, 15);
        x2 = signed_quot(mc * 32'd2048, x1 + md);
        b5 = x1 + x2;
        temp = sra(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        x1 = sra(sra(b2 * (b6 * b6), 12), 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra(((ac1 * 32'd4 + x3) << oss_set) + 32'd2, 2);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * sra(b6 * b6, 12), 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = (up - b3) * (32'd50000 >> oss_set);
        if (!b7[31]) p = unsigned_quot(b7 * 32'd2, b4);
        else p = unsigned_quot(b7, b4) * 32'd2;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(-32'd7357 * p, 16);
        p = p + sra(x1 + x2 + 32'd3791, 4);
        r.temp_tenths = temp;
        r.press_pa = p;
        r.temp_changed = outside_band(temp, last_temp, {22'd0, tthr});
        r.press_changed = outside_band(p, last_press, {16'd0, pthr});
        if (r.temp_changed) last_temp = temp;
        if (r.press_changed) last_press = p;
        return r;
    endfunction

    function automatic bit take_gap();
        return idle_on && ($urandom_range(99) < 33);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 3'd0}; pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_CAL_A: cal_a = v;
            REG_CAL_B: cal_b = v;
            REG_CAL_C: cal_c = v[31:0];
            REG_OSS:   oss_set = v[1:0];
            REG_TTHR:  tthr = v[9:0];
            default:   pthr = v[15:0];
        endcase
    endtask

    task automatic send_sample(input logic [15:0] t, input logic [23:0] pr);
        t_in_beat b;
        b.raw_temp = t;
        b.raw_press = pr;
        @(negedge i_clk);
        while (take_gap()) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(compensate(b));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // typical datasheet calibration
    task automatic load_typical_cal(input logic [1:0] oss);
        write_reg(REG_CAL_A, {16'd32741, 16'hFFC7 - 16'd0, 16'hFFB8, 16'd408});
        write_reg(REG_CAL_B, {16'd4, 16'd6190, 16'd23153, 16'd32757});
        write_reg(REG_CAL_C, {16'd2868, 16'hD4BD});
        write_reg(REG_OSS, {62'd0, oss});
    endtask

    task automatic test_directed();
        load_typical_cal(2'd0);
        send_sample(16'd27898, 24'd23843 << 8);
        send_sample(16'd0, 24'd0);
        send_sample(16'hFFFF, 24'hFFFFFF);
        send_sample(16'h8000, 24'h800000);
        send_sample(16'd27898, 24'd23843 << 8);
        drain();
        write_reg(REG_OSS, 64'd3);
        write_reg(REG_TTHR, 64'd0);
        write_reg(REG_PTHR, 64'd0);
        send_sample(16'd27898, 24'h5D2300);
        send_sample(16'd27898, 24'h5D2300);
        send_sample(16'h0001, 24'h000001);
        drain();
        // zero divisors on both divisions
        write_reg(REG_CAL_A, 64'd0);
        write_reg(REG_CAL_B, 64'd0);
        write_reg(REG_CAL_C, 64'd0);
        send_sample(16'd1234, 24'd5678);
        drain();
        // most negative MC with a divisor of minus one
        write_reg(REG_CAL_C, {16'hFFFF, 16'h8000});
        write_reg(REG_CAL_B, {32'd0, 16'd0, 16'd0});
        send_sample(16'd0, 24'hABCDEF);
        drain();
        write_reg(REG_CAL_A, '1);
        write_reg(REG_CAL_B, '1);
        write_reg(REG_CAL_C, 64'hFFFF_FFFF);
        write_reg(REG_TTHR, 64'd1023);
        write_reg(REG_PTHR, 64'd65535);
        send_sample(16'hFFFF, 24'hFFFFFF);
        send_sample(16'h0000, 24'h000000);
        send_sample(16'h5555, 24'hAAAAAA);
        send_sample(16'hAAAA, 24'h555555);
        drain();
    endtask

    task automatic test_random_phase(input int count, input bit typical);
        if (typical) load_typical_cal(2'($urandom_range(3)));
        else begin
            write_reg(REG_CAL_A, {$urandom, $urandom});
            write_reg(REG_CAL_B, {$urandom, $urandom});
            write_reg(REG_CAL_C, {32'd0, $urandom});
            write_reg(REG_OSS, 64'($urandom_range(3)));
        end
        write_reg(REG_TTHR, 64'($urandom_range(1023)));
        write_reg(REG_PTHR, 64'($urandom_range(3) == 0 ? $urandom_range(65535)
                                                       : $urandom_range(300)));
        repeat (count) begin
            if (typical)
                send_sample(16'($urandom_range(24000, 32000)),
                            24'($urandom_range(20000 << 8, 30000 << 8)));
            else
                send_sample(16'($urandom), 24'($urandom));
        end
        drain();
    endtask

    initial begin : out_stall
        forever begin
            @(negedge i_clk);
            i_out_ready = !take_gap();
        end
    end

    initial begin : result_check
        t_out_beat exp_beat;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %h", o_out_data);
                end else begin
                    exp_beat = pending_results.pop_front();
                    if (exp_beat !== o_out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp t=%0d p=%0d tc=%b pc=%b got t=%0d p=%0d tc=%b pc=%b",
                                     $signed(exp_beat.temp_tenths), $signed(exp_beat.press_pa),
                                     exp_beat.temp_changed, exp_beat.press_changed,
                                     $signed(o_out_data.temp_tenths),
                                     $signed(o_out_data.press_pa),
                                     o_out_data.temp_changed, o_out_data.press_changed);
                    end
                end
            end
        end
    end

    initial begin : time_limit
        #20ms;
        $display("baro_sensor_compensation_core test failed");
        $finish;
    end

    initial begin
        cal_a = '0; cal_b = '0; cal_c = '0;
        oss_set = 2'd1; tthr = 10'd5; pthr = 16'd100;
        last_temp = '0; last_press = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // reset settings first
        send_sample(16'd27898, 24'h5D2300);
        drain();
        test_directed();
        for (int ph = 0; ph < 10; ph++) begin
            idle_on = (ph != 4);
            test_random_phase(150, ph % 2 == 0);
        end
        if (pending_results.size() == 0 && mismatches == 0)
            $display("baro_sensor_compensation_core test passed");
        else
            $display("baro_sensor_compensation_core test failed");
        $finish;
    end

endmodule

// ===== baro_sensor_compensation_core.f =====
+incdir+hw/rtl
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_div.sv
hw/rtl/bsc_datapath.sv
hw/rtl/bsc_ctrl.sv
hw/rtl/baro_sensor_compensation_core.sv
tb/sv/baro_sensor_compensation_core_tb.sv
